// File: rtl/ecfm_pkg.sv
// ----------------------------------------------------------------------------
// ecfm_pkg
// Shared codes and types of the fan-control mailbox: transaction phases,
// command, op and selector bytes, the status bit, bus access kinds and ports, byte positions, version reset.
// ----------------------------------------------------------------------------
package ecfm_pkg;

    // Transaction phase of the command/data sequence.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_PROBE  = 3'd2,
        PH_TABLE  = 3'd3
    } t_phase;

    // Bytes seen on the command port.
    localparam logic [7:0] PFX_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_PROBE  = 8'hBB;
    localparam logic [7:0] CMD_TABLE  = 8'hDD;

    // Bytes seen on the data port.
    localparam logic [7:0] PROBE_Q    = 8'h50;
    localparam logic [7:0] OP_READ    = 8'h02;
    localparam logic [7:0] OP_WRITE   = 8'h82;
    localparam logic [7:0] SEL_MANUAL = 8'h31;
    localparam logic [7:0] SEL_INDEX  = 8'h32;
    localparam logic [7:0] SEL_DUTY   = 8'h35;

    // Status byte bit: output buffer full.
    localparam logic [7:0] ST_OBF     = 8'h01;

    // Bus access kind and port.
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;
    localparam logic PORT_DATA  = 1'b0;
    localparam logic PORT_CMD   = 1'b1;

    // Position of the table transaction's data byte.
    localparam logic [1:0] BC_OP  = 2'd0;
    localparam logic [1:0] BC_SEL = 2'd1;
    localparam logic [1:0] BC_ARG = 2'd2;

    localparam logic [7:0] VERSION_RESET = 8'h01;

endpackage

// File: rtl/ec_fan_mailbox_device.sv
// ----------------------------------------------------------------------------
// ec_fan_mailbox_device
// Device side of a two-port mailbox with per-fan manual flag and duty.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one bus access per word:
//   i_mode (0 read, 1 write), i_port_sel (0 data, 1 status/command) and
//   i_wdata. Output channel (o_valid / i_ready) returns one word per
//   access: read data, the manual flag and duty of both fans after the
//   access, and a protocol error flag.
//   The whole decode and state update sits between the accept edge and
//   the result register. Throughput is one access per cycle; the result
//   register is the only stage, so the block takes a new access whenever
//   the result register is empty or being drained in the same cycle.
//   When the receiver stalls, the held result stays put and o_ready drops
//   until it is taken; no access is lost or repeated.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle, clears
//   the fan index, flags, duties and output buffer, drops any pending
//   result and sets the interface version to 1. The user writes the
//   version (i_cfg_we / i_cfg_wdata) only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module ec_fan_mailbox_device #(
    parameter int NUM_FANS = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // access channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic       i_port_sel,
    input  logic [7:0] i_wdata,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_rdata,
    output logic       o_cpu_manual,
    output logic [7:0] o_cpu_duty,
    output logic       o_gpu_manual,
    output logic [7:0] o_gpu_duty,
    output logic       o_protocol_error
);

    // Highest legal fan index plus one, as a byte for the range check.
    localparam logic [7:0] FAN_LIMIT = 8'(NUM_FANS);

    // Sequencer and mailbox state.
    ecfm_pkg::t_phase r_phase, n_phase;
    logic [1:0] r_byte_count, n_byte_count;
    logic [7:0] r_op_code, n_op_code;
    logic [7:0] r_selector, n_selector;
    logic       r_fan_index, n_fan_index;
    logic       r_manual [0:NUM_FANS-1];
    logic       n_manual [0:NUM_FANS-1];
    logic [7:0] r_duty   [0:NUM_FANS-1];
    logic [7:0] n_duty   [0:NUM_FANS-1];
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_full, n_out_full;
    logic [7:0] r_version;

    // Result register.
    logic       r_res_valid;
    logic [7:0] r_rdata, n_rdata;
    logic       r_err, n_err;
    logic       r_cpu_manual, r_gpu_manual, n_cpu_manual, n_gpu_manual;
    logic [7:0] r_cpu_duty, r_gpu_duty, n_cpu_duty, n_gpu_duty;

    logic       acc;
    logic       cmd_wr, data_wr;
    logic       sel_manual_q, sel_index_q;
    logic       cur_manual;
    logic [7:0] cur_duty;

    // Accept while the result register is empty or draining.
    assign o_ready = !r_res_valid || i_ready;
    assign acc     = i_valid && o_ready;

    assign cmd_wr  = (i_mode == ecfm_pkg::MODE_WRITE) && (i_port_sel == ecfm_pkg::PORT_CMD);
    assign data_wr = (i_mode == ecfm_pkg::MODE_WRITE) && (i_port_sel == ecfm_pkg::PORT_DATA);

    assign sel_manual_q = (r_selector == ecfm_pkg::SEL_MANUAL);
    assign sel_index_q  = (r_selector == ecfm_pkg::SEL_INDEX);

    // Flag and duty of the currently indexed fan.
    always_comb begin
        cur_manual = r_manual[0];
        cur_duty   = r_duty[0];
        for (int f = 1; f < NUM_FANS; f++) begin
            if (r_fan_index == f[0]) begin
                cur_manual = r_manual[f];
                cur_duty   = r_duty[f];
            end
        end
    end

    // Next phase and byte position. Reads never move the sequence.
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        if (cmd_wr) begin
            if (i_wdata == ecfm_pkg::PFX_BYTE) begin
                n_phase      = ecfm_pkg::PH_PREFIX;
                n_byte_count = '0;
            end else if (r_phase == ecfm_pkg::PH_PREFIX && i_wdata == ecfm_pkg::CMD_PROBE) begin
                n_phase      = ecfm_pkg::PH_PROBE;
                n_byte_count = '0;
            end else if (r_phase == ecfm_pkg::PH_PREFIX && i_wdata == ecfm_pkg::CMD_TABLE) begin
                n_phase      = ecfm_pkg::PH_TABLE;
                n_byte_count = '0;
            end else begin
                n_phase      = ecfm_pkg::PH_IDLE;
                n_byte_count = '0;
            end
        end else if (data_wr) begin
            n_phase      = ecfm_pkg::PH_IDLE;
            n_byte_count = '0;
            if (r_phase == ecfm_pkg::PH_TABLE) begin
                case (r_byte_count)
                    ecfm_pkg::BC_OP: begin
                        if (i_wdata == ecfm_pkg::OP_READ || i_wdata == ecfm_pkg::OP_WRITE) begin
                            n_phase      = ecfm_pkg::PH_TABLE;
                            n_byte_count = ecfm_pkg::BC_SEL;
                        end
                    end
                    ecfm_pkg::BC_SEL: begin
                        if (i_wdata == ecfm_pkg::SEL_MANUAL || i_wdata == ecfm_pkg::SEL_INDEX ||
                            i_wdata == ecfm_pkg::SEL_DUTY) begin
                            n_phase      = ecfm_pkg::PH_TABLE;
                            n_byte_count = ecfm_pkg::BC_ARG;
                        end
                    end
                    default: begin
                        n_phase      = ecfm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Datapath: output buffer, table updates, error and read data.
    always_comb begin
        n_op_code   = r_op_code;
        n_selector  = r_selector;
        n_fan_index = r_fan_index;
        n_out_byte  = r_out_byte;
        n_out_full  = r_out_full;
        n_err       = 1'b0;
        n_rdata     = '0;
        for (int f = 0; f < NUM_FANS; f++) begin
            n_manual[f] = r_manual[f];
            n_duty[f]   = r_duty[f];
        end

        if (i_mode == ecfm_pkg::MODE_READ) begin
            if (i_port_sel == ecfm_pkg::PORT_CMD) begin
                n_rdata = r_out_full ? ecfm_pkg::ST_OBF : 8'h00;
            end else begin
                // pop the output byte; an empty pop returns the stale byte
                n_rdata    = r_out_byte;
                n_out_full = 1'b0;
            end
        end else if (i_port_sel == ecfm_pkg::PORT_CMD) begin
            if (i_wdata == ecfm_pkg::PFX_BYTE) begin
                // prefix always restarts; flag it if something was open
                n_err = (r_phase != ecfm_pkg::PH_IDLE);
            end else if (!(r_phase == ecfm_pkg::PH_PREFIX &&
                           (i_wdata == ecfm_pkg::CMD_PROBE || i_wdata == ecfm_pkg::CMD_TABLE))) begin
                n_err = 1'b1;
            end
        end else begin
            case (r_phase)
                ecfm_pkg::PH_PROBE: begin
                    if (i_wdata == ecfm_pkg::PROBE_Q) begin
                        n_out_byte = r_version;
                        n_out_full = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                ecfm_pkg::PH_TABLE: begin
                    case (r_byte_count)
                        ecfm_pkg::BC_OP: begin
                            n_op_code = i_wdata;
                            n_err = !(i_wdata == ecfm_pkg::OP_READ ||
                                      i_wdata == ecfm_pkg::OP_WRITE);
                        end
                        ecfm_pkg::BC_SEL: begin
                            n_selector = i_wdata;
                            n_err = !(i_wdata == ecfm_pkg::SEL_MANUAL ||
                                      i_wdata == ecfm_pkg::SEL_INDEX ||
                                      i_wdata == ecfm_pkg::SEL_DUTY);
                        end
                        default: begin
                            // value byte: run the table access
                            if (r_op_code == ecfm_pkg::OP_WRITE) begin
                                if (sel_index_q) begin
                                    if (i_wdata >= FAN_LIMIT) begin
                                        n_err = 1'b1;
                                    end else begin
                                        n_fan_index = i_wdata[0];
                                    end
                                end else begin
                                    for (int f = 0; f < NUM_FANS; f++) begin
                                        if (r_fan_index == f[0]) begin
                                            if (sel_manual_q) begin
                                                n_manual[f] = |i_wdata;
                                            end else begin
                                                n_duty[f] = i_wdata;
                                            end
                                        end
                                    end
                                end
                            end else begin
                                n_out_full = 1'b1;
                                if (sel_index_q) begin
                                    n_out_byte = {7'b0, r_fan_index};
                                end else if (sel_manual_q) begin
                                    n_out_byte = {7'b0, cur_manual};
                                end else begin
                                    n_out_byte = cur_duty;
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    // stray data byte outside a probe or table transaction
                    n_err = 1'b1;
                end
            endcase
        end
    end

    // Fan views after the update; the second fan reads zero when absent.
    assign n_cpu_manual = n_manual[0];
    assign n_cpu_duty   = n_duty[0];
    generate
        if (NUM_FANS > 1) begin : g_two_fans
            assign n_gpu_manual = n_manual[1];
            assign n_gpu_duty   = n_duty[1];
        end else begin : g_one_fan
            assign n_gpu_manual = 1'b0;
            assign n_gpu_duty   = '0;
        end
    endgenerate

    // Control and mailbox state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ecfm_pkg::PH_IDLE;
            r_byte_count <= '0;
            r_op_code    <= '0;
            r_selector   <= '0;
            r_fan_index  <= 1'b0;
            r_out_byte   <= '0;
            r_out_full   <= 1'b0;
            r_version    <= ecfm_pkg::VERSION_RESET;
            r_res_valid  <= 1'b0;
            for (int f = 0; f < NUM_FANS; f++) begin
                r_manual[f] <= 1'b0;
                r_duty[f]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_version <= i_cfg_wdata;
            end
            if (acc) begin
                r_phase      <= n_phase;
                r_byte_count <= n_byte_count;
                r_op_code    <= n_op_code;
                r_selector   <= n_selector;
                r_fan_index  <= n_fan_index;
                r_out_byte   <= n_out_byte;
                r_out_full   <= n_out_full;
                for (int f = 0; f < NUM_FANS; f++) begin
                    r_manual[f] <= n_manual[f];
                    r_duty[f]   <= n_duty[f];
                end
            end
            if (acc) begin
                r_res_valid <= 1'b1;
            end else if (i_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rdata      <= n_rdata;
            r_err        <= n_err;
            r_cpu_manual <= n_cpu_manual;
            r_cpu_duty   <= n_cpu_duty;
            r_gpu_manual <= n_gpu_manual;
            r_gpu_duty   <= n_gpu_duty;
        end
    end

    assign o_valid          = r_res_valid;
    assign o_rdata          = r_rdata;
    assign o_cpu_manual     = r_cpu_manual;
    assign o_cpu_duty       = r_cpu_duty;
    assign o_gpu_manual     = r_gpu_manual;
    assign o_gpu_duty       = r_gpu_duty;
    assign o_protocol_error = r_err;

endmodule
